// File: src/flsrv_pkg.sv
// flsrv_pkg: shared types and codes for the fifo lock server core.
// Holds field widths, status and action codes, and the controller/datapath
// command and status structs. No dependencies.
package flsrv_pkg;

   localparam int ID_W     = 6;
   localparam int STATUS_W = 3;
   localparam int ACT_W    = 3;

   localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WAITING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PASSED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd5;

   localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WAITING = 3'd2;
   localparam logic [ACT_W-1:0] ACT_IGNORE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FREE    = 3'd5;
   localparam logic [ACT_W-1:0] ACT_PASS    = 3'd6;
   localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd7;

   typedef struct packed {
      logic             take;
      logic             load_item;
      logic             scan_init;
      logic             scan_run;
      logic             head_read;
      logic             move_init;
      logic             move_run;
      logic             move_done;
      logic             finish;
      logic [ACT_W-1:0] act;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_lock;
      logic held;
      logic is_holder;
      logic count_zero;
      logic full;
      logic scan_hit;
      logic scan_end;
      logic move_end;
      logic rsp_free;
   } sts_type;

endpackage

// File: src/flsrv_if.sv
// flsrv_if: valid/ready channel interfaces for lock requests and responses.
// Depends on flsrv_pkg for field widths.
interface lock_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [flsrv_pkg::ID_W-1:0] requester;

   modport source (output valid, output op, output requester, input ready);
   modport sink   (input valid, input op, input requester, output ready);
endinterface

interface lock_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           grant_valid;
   logic [flsrv_pkg::ID_W-1:0]     grant_id;
   logic [flsrv_pkg::STATUS_W-1:0] status;

   modport source (output valid, output grant_valid, output grant_id, output status,
                   input ready);
   modport sink   (input valid, input grant_valid, input grant_id, input status,
                   output ready);
endinterface

// File: src/flsrv_ram.sv
// flsrv_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module flsrv_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/flsrv_ctrl.sv
// flsrv_ctrl: sequencing state machine of the lock server.
// Depends on flsrv_pkg; drives flsrv_datapath via cmd_type/sts_type.
module flsrv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  flsrv_pkg::sts_type sts,
   output flsrv_pkg::cmd_type cmd
);
   import flsrv_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_HEAD   = 3'd3;
   localparam logic [2:0] S_MOVE   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cmd.take = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (sts.req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_lock && !sts.held) begin
               cmd.act  = ACT_GRANT;
               state_in = S_DONE;
            end else if (!sts.is_lock && sts.is_holder) begin
               if (sts.count_zero) begin
                  cmd.act  = ACT_FREE;
                  state_in = S_DONE;
               end else begin
                  cmd.head_read = 1'b1;
                  state_in      = S_HEAD;
               end
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_hit) begin
               if (sts.is_lock) begin
                  cmd.act  = ACT_WAITING;
                  state_in = S_DONE;
               end else begin
                  cmd.act       = ACT_REMOVE;
                  cmd.move_init = 1'b1;
                  state_in      = S_MOVE;
               end
            end else if (sts.scan_end) begin
               if (sts.is_lock && !sts.full) begin
                  cmd.act = ACT_APPEND;
               end else begin
                  cmd.act = ACT_IGNORE;
               end
               state_in = S_DONE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_HEAD: begin
            cmd.act       = ACT_PASS;
            cmd.move_init = 1'b1;
            state_in      = S_MOVE;
         end
         S_MOVE: begin
            if (sts.move_end) begin
               cmd.move_done = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.move_run = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/flsrv_datapath.sv
// flsrv_datapath: lock state, wait list RAM with search and compaction pointers,
// and the response register. Depends on flsrv_pkg, flsrv_if, flsrv_ram.
module flsrv_datapath #(
   parameter int MAX_NODES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  flsrv_pkg::cmd_type cmd,
   output flsrv_pkg::sts_type sts,
   lock_req_if.sink           req,
   lock_rsp_if.source         rsp
);
   import flsrv_pkg::*;

   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int AW = $clog2(MAX_NODES);

   logic                op_ff, op_in;
   logic [ID_W-1:0]     who_ff, who_in;
   logic                held_ff, held_in;
   logic [ID_W-1:0]     holder_ff, holder_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic                res_grant_ff, res_grant_in;
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_grant_ff, rsp_grant_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ID_W-1:0]     ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [ID_W-1:0]     ram_rdata;
   logic                idx_lt;
   logic                appending;

   assign idx_lt    = (idx_ff < count_ff);
   assign appending = (cmd.act == ACT_APPEND);

   assign ram_we    = wr_pend_ff || appending;
   assign ram_waddr = appending ? count_ff[AW-1:0] : wr_addr_ff;
   assign ram_wdata = appending ? who_ff : ram_rdata;
   assign ram_raddr = cmd.head_read ? '0 : idx_ff[AW-1:0];

   flsrv_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_NODES)
   ) u_wait_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      op_in         = op_ff;
      who_in        = who_ff;
      held_in       = held_ff;
      holder_in     = holder_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      wr_pend_in    = wr_pend_ff;
      wr_addr_in    = wr_addr_ff;
      res_grant_in  = res_grant_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load_item) begin
         op_in  = req.op;
         who_in = req.requester;
      end
      if (cmd.scan_init) begin
         idx_in     = '0;
         cmp_vld_in = 1'b0;
      end
      if (cmd.scan_run) begin
         cmp_vld_in = idx_lt;
         cmp_idx_in = idx_ff;
         if (idx_lt) begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (cmd.move_init) begin
         idx_in     = (cmd.act == ACT_PASS) ? CW'(1) : cmp_idx_ff + CW'(1);
         wr_pend_in = 1'b0;
      end
      if (cmd.move_run) begin
         // beat read at idx lands one slot lower next cycle
         wr_pend_in = idx_lt;
         wr_addr_in = idx_ff[AW-1:0] - AW'(1);
         if (idx_lt) begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (cmd.move_done) begin
         count_in = count_ff - CW'(1);
      end

      unique case (cmd.act) inside
         ACT_GRANT: begin
            held_in       = 1'b1;
            holder_in     = who_ff;
            res_grant_in  = 1'b1;
            res_id_in     = who_ff;
            res_status_in = ST_GRANTED;
         end
         ACT_WAITING: begin
            res_grant_in  = 1'b0;
            res_id_in     = '0;
            res_status_in = ST_WAITING;
         end
         ACT_IGNORE, ACT_REMOVE: begin
            res_grant_in  = 1'b0;
            res_id_in     = '0;
            res_status_in = ST_IGNORED;
         end
         ACT_APPEND: begin
            count_in      = count_ff + CW'(1);
            res_grant_in  = 1'b0;
            res_id_in     = '0;
            res_status_in = ST_QUEUED;
         end
         ACT_FREE: begin
            held_in       = 1'b0;
            holder_in     = '0;
            res_grant_in  = 1'b0;
            res_id_in     = '0;
            res_status_in = ST_FREED;
         end
         ACT_PASS: begin
            holder_in     = ram_rdata;
            res_grant_in  = 1'b1;
            res_id_in     = ram_rdata;
            res_status_in = ST_PASSED;
         end
         default: ;
      endcase

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_grant_in  = res_grant_ff;
         rsp_id_in     = res_id_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         holder_ff    <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         holder_ff    <= holder_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      who_ff        <= who_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      wr_addr_ff    <= wr_addr_in;
      res_grant_ff  <= res_grant_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready       = cmd.take;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.grant_valid = rsp_grant_ff;
   assign rsp.grant_id    = rsp_id_ff;
   assign rsp.status      = rsp_status_ff;

   assign sts.req_valid  = req.valid;
   assign sts.is_lock    = !op_ff;
   assign sts.held       = held_ff;
   assign sts.is_holder  = held_ff && (who_ff == holder_ff);
   assign sts.count_zero = (count_ff == '0);
   assign sts.full       = (count_ff == CW'(MAX_NODES));
   assign sts.scan_hit   = cmp_vld_ff && (ram_rdata == who_ff);
   assign sts.scan_end   = !idx_lt && !cmp_vld_ff;
   assign sts.move_end   = !idx_lt && !wr_pend_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp.ready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("wait count above capacity");

   a_free_no_holder: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> (holder_ff == '0))
      else $error("free lock with nonzero holder");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> ((CW'(wr_addr_ff) + CW'(1)) < count_ff))
      else $error("compaction write outside list");

   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == ACT_GRANT) |-> !held_ff)
      else $error("direct grant while lock held");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

// File: src/fifo_lock_server_core.sv
// fifo_lock_server_core: top level of the central lock server with FIFO wait list.
// Depends on flsrv_pkg, flsrv_if, flsrv_ctrl, flsrv_datapath (with flsrv_ram).
//
//   channel   dir   payload                               handshake
//   req_bus   in    op, requester                         valid/ready
//   rsp_bus   out   grant_valid, grant_id, status         valid/ready
//
// One item at a time: a new req_bus beat is taken only once the previous item has
// finished. Lock grants and plain releases decide without touching the wait list; other
// items scan it, and pass-on and waiter removal compact it (one wait-list RAM read per cycle).
// Synchronous reset empties the list at once (count only); no clearing pass.
// A result waiting on rsp_bus does not block the next req_bus beat; it holds only
// the finish of that next item.
module fifo_lock_server_core #(
   parameter int MAX_NODES = 64
) (
   input logic        clock,
   input logic        reset,
   lock_req_if.sink   req_bus,
   lock_rsp_if.source rsp_bus
);
   import flsrv_pkg::*;

   cmd_type cmd;
   sts_type sts;

   flsrv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   flsrv_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule
